// ----- sv/oxc_pkg.sv -----
// Shared types and codes for the one-point order crossover block.
// No dependencies; compiled first.
package oxc_pkg;

  localparam int STORE_DEPTH = 32;
  localparam int ADDR_W      = 5;
  localparam int GENE_W      = 5;
  localparam int CNT_W       = 6;

  typedef logic [GENE_W-1:0] gene_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [1:0]        func_t;

  localparam func_t FUNC_LOAD_FIRST  = 2'd0;
  localparam func_t FUNC_LOAD_SECOND = 2'd1;
  localparam func_t FUNC_RUN         = 2'd2;

endpackage

// ----- sv/oxc_if.sv -----
// Valid/ready channels of the crossover block: request channel and result channel.
// Depends on oxc_pkg.
interface oxc_in_if;
  import oxc_pkg::*;
  logic  valid;
  logic  ready;
  func_t func;
  addr_t position;
  gene_t gene;
  addr_t cut_point;

  modport source (output valid, func, position, gene, cut_point, input ready);
  modport sink   (input valid, func, position, gene, cut_point, output ready);
endinterface

interface oxc_out_if;
  import oxc_pkg::*;
  logic  valid;
  logic  ready;
  gene_t child_gene;
  addr_t child_position;
  logic  last;

  modport source (output valid, child_gene, child_position, last, input ready);
  modport sink   (input valid, child_gene, child_position, last, output ready);
endinterface

// ----- sv/one_point_order_crossover_core.sv -----
// One-point order crossover of two tours.
// Requests arrive on "items": func 0 loads a first parent gene, func 1 a second
// parent gene (gene at position), func 2 runs the crossover with cut_point.
// func 3 is taken and ignored. Each load returns nothing.
// A run emits LEN = min(NUM_CITIES, 32) results on "results", positions 0 up
// to LEN-1, last set on the final one.
// A run first marks the kept prefix (first parent genes at positions 1 up
// to cut-1), then places second parent genes into the child memory, then
// emits the child genes; each gene takes a read step and then a use step,
// as each memory has a single registered read port. New requests are taken
// only while no run is in progress; the last result may still wait in the
// output register.
// When the receiver stalls, the emit step holds its position and the output
// register keeps its result until taken.
// Reset (rst, synchronous) returns the sequencer to idle and drops any
// pending result. The parent memories are not cleared: every gene a run
// reads must have been loaded first.
// Depends on oxc_pkg and oxc_if.
module one_point_order_crossover_core #(
  parameter int NUM_CITIES = 32
) (
  input logic clk,
  input logic rst,
  oxc_in_if.sink    items,
  oxc_out_if.source results
);
  import oxc_pkg::*;

  localparam int LEN_I = (NUM_CITIES > STORE_DEPTH) ? STORE_DEPTH : NUM_CITIES;
  localparam logic [CNT_W-1:0] LEN      = CNT_W'(LEN_I);
  localparam logic [CNT_W-1:0] LEN_LAST = CNT_W'(LEN_I - 1);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_PRE_RD   = 3'd1;
  localparam logic [2:0] S_PRE_USE  = 3'd2;
  localparam logic [2:0] S_FILL_RD  = 3'd3;
  localparam logic [2:0] S_FILL_USE = 3'd4;
  localparam logic [2:0] S_EMIT_RD  = 3'd5;
  localparam logic [2:0] S_EMIT_USE = 3'd6;

  logic [2:0]             state;
  logic [CNT_W-1:0]       idx;
  logic [CNT_W-1:0]       cut;
  logic [CNT_W-1:0]       dest;
  logic [STORE_DEPTH-1:0] member;

  gene_t first_mem  [STORE_DEPTH];
  gene_t second_mem [STORE_DEPTH];
  gene_t child_mem  [STORE_DEPTH];
  gene_t first_q;
  gene_t second_q;
  gene_t child_q;

  logic             accept;
  logic             out_free;
  logic             emit_load;
  logic [CNT_W-1:0] cut_req;
  gene_t            emit_gene;

  assign items.ready = (state == S_IDLE);
  assign accept      = items.valid && items.ready;
  assign out_free    = !results.valid || results.ready;
  assign emit_load   = (state == S_EMIT_USE) && out_free;

  // zero cut acts as 1; a cut past the tour keeps the whole first parent
  always_comb begin
    cut_req = {1'b0, items.cut_point};
    if (cut_req == '0) begin
      cut_req = CNT_W'(1);
    end
    if (cut_req > LEN) begin
      cut_req = LEN;
    end
  end

  always_comb begin
    if (idx == '0) begin
      emit_gene = '0;
    end else if (idx >= cut && idx < dest) begin
      emit_gene = child_q;
    end else begin
      emit_gene = first_q;
    end
  end

  // parent and child memories, one registered read port each
  always_ff @(posedge clk) begin
    if (accept && items.func == FUNC_LOAD_FIRST) begin
      first_mem[items.position] <= items.gene;
    end
    if (accept && items.func == FUNC_LOAD_SECOND) begin
      second_mem[items.position] <= items.gene;
    end
    if (state == S_FILL_USE && !member[second_q] && dest < LEN) begin
      child_mem[dest[ADDR_W-1:0]] <= second_q;
    end
    first_q  <= first_mem[idx[ADDR_W-1:0]];
    second_q <= second_mem[idx[ADDR_W-1:0]];
    child_q  <= child_mem[idx[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      idx    <= '0;
      cut    <= '0;
      dest   <= '0;
      member <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept && items.func == FUNC_RUN) begin
            cut    <= cut_req;
            dest   <= cut_req;
            member <= '0;
            idx    <= CNT_W'(1);
            state  <= (cut_req == CNT_W'(1)) ? S_FILL_RD : S_PRE_RD;
          end
        end
        S_PRE_RD: begin
          state <= S_PRE_USE;
        end
        S_PRE_USE: begin
          member[first_q] <= 1'b1;
          if (idx + CNT_W'(1) == cut) begin
            idx   <= CNT_W'(1);
            state <= S_FILL_RD;
          end else begin
            idx   <= idx + CNT_W'(1);
            state <= S_PRE_RD;
          end
        end
        S_FILL_RD: begin
          state <= S_FILL_USE;
        end
        S_FILL_USE: begin
          if (!member[second_q]) begin
            dest <= dest + CNT_W'(1);
          end
          if (idx == LEN_LAST) begin
            idx   <= '0;
            state <= S_EMIT_RD;
          end else begin
            idx   <= idx + CNT_W'(1);
            state <= S_FILL_RD;
          end
        end
        S_EMIT_RD: begin
          state <= S_EMIT_USE;
        end
        S_EMIT_USE: begin
          if (out_free) begin
            if (idx == LEN_LAST) begin
              idx   <= '0;
              state <= S_IDLE;
            end else begin
              idx   <= idx + CNT_W'(1);
              state <= S_EMIT_RD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (emit_load) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      results.child_gene     <= emit_gene;
      results.child_position <= idx[ADDR_W-1:0];
      results.last           <= (idx == LEN_LAST);
    end
  end

endmodule

// ----- verif/tb_one_point_order_crossover_core.sv -----
`timescale 1ns / 100ps
// Testbench for one_point_order_crossover_core: loads parent tours, runs crossovers and
// checks every child gene against an in-bench order crossover predictor.
// Depends on oxc_pkg, oxc_if and the core RTL.
module tb_one_point_order_crossover_core;
  import oxc_pkg::*;

  localparam int    NUM_CITIES  = 32;
  localparam int    TOUR_LEN    = (NUM_CITIES < STORE_DEPTH) ? NUM_CITIES : STORE_DEPTH;
  localparam int    CYCLE_LIMIT = 1000000;
  localparam int    MAX_GAP     = 64;
  localparam func_t FUNC_UNUSED = 2'd3;

  typedef struct packed {
    gene_t child_gene;
    addr_t child_position;
    logic  last;
  } child_gene_t;

  logic        clk;
  logic        rst;
  logic        rx_ready = 1'b0;
  int          sender_idle_pct;
  int          receiver_stall_pct;
  int          requests_sent;
  int          mismatch_count;
  int          cycle_count;
  gene_t       first_parent_genes [STORE_DEPTH];
  gene_t       second_parent_genes[STORE_DEPTH];
  child_gene_t expected_child_genes[$];

  oxc_in_if  items_if ();
  oxc_out_if results_if ();

  one_point_order_crossover_core #(.NUM_CITIES(NUM_CITIES)) u_top (
    .clk     (clk),
    .rst     (rst),
    .items   (items_if),
    .results (results_if)
  );

  assign results_if.ready = rx_ready;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  always @(negedge clk) begin
    rx_ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // Builds the child tour from the current parent copies and queues one
  // expected result per position.
  function automatic void predict_child_tour(addr_t cut_field);
    bit          kept_city[STORE_DEPTH];
    gene_t       child[STORE_DEPTH];
    int          cut;
    int          placed;
    gene_t       g;
    child_gene_t exp_gene;
    cut = (cut_field == 0) ? 1 : int'(cut_field);
    if (cut > TOUR_LEN) cut = TOUR_LEN;
    foreach (kept_city[c]) kept_city[c] = 1'b0;
    child[0] = '0;
    for (int p = 1; p < TOUR_LEN; p++) begin
      child[p] = first_parent_genes[p];
      if (p < cut) kept_city[first_parent_genes[p]] = 1'b1;
    end
    placed = 0;
    for (int p = 1; p < TOUR_LEN; p++) begin
      g = second_parent_genes[p];
      if (!kept_city[g]) begin
        // fills past the end of the tour are dropped
        if (cut + placed < TOUR_LEN) child[cut + placed] = g;
        placed++;
      end
    end
    for (int k = 0; k < TOUR_LEN; k++) begin
      exp_gene.child_gene     = child[k];
      exp_gene.child_position = addr_t'(k);
      exp_gene.last           = (k == TOUR_LEN - 1);
      expected_child_genes.push_back(exp_gene);
    end
  endfunction

  task automatic send_request(func_t func, addr_t position, gene_t gene, addr_t cut_point);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct) gap++;
    @(negedge clk);
    if (gap > 0) begin
      items_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    items_if.valid     <= 1'b1;
    items_if.func      <= func;
    items_if.position  <= position;
    items_if.gene      <= gene;
    items_if.cut_point <= cut_point;
    @(posedge clk);
    while (!items_if.ready) @(posedge clk);
    requests_sent++;
    case (func)
      FUNC_LOAD_FIRST:  first_parent_genes[position]  = gene;
      FUNC_LOAD_SECOND: second_parent_genes[position] = gene;
      FUNC_RUN:         predict_child_tour(cut_point);
      default: ;
    endcase
  endtask

  task automatic start_crossover(addr_t cut);
    send_request(FUNC_RUN, addr_t'($urandom_range(31)), gene_t'($urandom_range(31)), cut);
  endtask

  // Sender goes quiet until every queued child gene has come back.
  task automatic drain_child_tours();
    @(negedge clk);
    items_if.valid <= 1'b0;
    while (expected_child_genes.size() != 0) @(posedge clk);
  endtask

  // City 0 at position 0, a random permutation of cities 1..31 after it.
  task automatic load_parent_tour(func_t which);
    gene_t tour[STORE_DEPTH];
    gene_t tmp;
    int    j;
    for (int p = 0; p < STORE_DEPTH; p++) tour[p] = gene_t'(p);
    for (int p = STORE_DEPTH - 1; p > 1; p--) begin
      j       = $urandom_range(p, 1);
      tmp     = tour[p];
      tour[p] = tour[j];
      tour[j] = tmp;
    end
    for (int p = 0; p < STORE_DEPTH; p++) begin
      send_request(which, addr_t'(p), tour[p], addr_t'($urandom_range(31)));
    end
  endtask

  task automatic test_directed_cases();
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    load_parent_tour(FUNC_LOAD_FIRST);
    load_parent_tour(FUNC_LOAD_SECOND);
    start_crossover(5'd0);   // zero cut acts as an empty kept prefix
    start_crossover(5'd1);
    start_crossover(5'd31);  // only the last position takes a fill
    start_crossover(5'd16);
    send_request(FUNC_UNUSED, '1, '1, '1);
    send_request(FUNC_LOAD_FIRST, '0, '1, '0);  // position 0 is written but never read
    send_request(FUNC_LOAD_FIRST, 5'd31, '0, '1);
    send_request(FUNC_LOAD_SECOND, 5'd1, 5'd31, '0);
    send_request(FUNC_LOAD_SECOND, 5'd31, '0, '1);
    start_crossover(5'd2);
    drain_child_tours();
    start_crossover(5'd8);
    drain_child_tours();
  endtask

  task automatic test_random_traffic(int idle_pct, int stall_pct, int n_requests);
    int    first_request;
    int    kind;
    int    a;
    int    b;
    gene_t ga;
    gene_t gb;
    func_t which;
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    first_request      = requests_sent;
    while (requests_sent - first_request < n_requests) begin
      kind  = $urandom_range(99);
      which = $urandom_range(1) ? FUNC_LOAD_SECOND : FUNC_LOAD_FIRST;
      if (kind < 10) begin
        load_parent_tour(FUNC_LOAD_FIRST);
        load_parent_tour(FUNC_LOAD_SECOND);
      end else if (kind < 60) begin
        // swap two genes; a permutation stays a permutation
        a  = $urandom_range(STORE_DEPTH - 1, 1);
        b  = $urandom_range(STORE_DEPTH - 1, 1);
        ga = (which == FUNC_LOAD_FIRST) ? first_parent_genes[a] : second_parent_genes[a];
        gb = (which == FUNC_LOAD_FIRST) ? first_parent_genes[b] : second_parent_genes[b];
        send_request(which, addr_t'(a), gb, addr_t'($urandom_range(31)));
        send_request(which, addr_t'(b), ga, addr_t'($urandom_range(31)));
      end else if (kind < 80) begin
        // arbitrary genes: duplicates make short or dropped fills
        repeat ($urandom_range(4, 1)) begin
          send_request($urandom_range(1) ? FUNC_LOAD_SECOND : FUNC_LOAD_FIRST,
                       addr_t'($urandom_range(31)), gene_t'($urandom_range(31)),
                       addr_t'($urandom_range(31)));
        end
      end else if (kind < 90) begin
        send_request(FUNC_UNUSED, addr_t'($urandom_range(31)), gene_t'($urandom_range(31)),
                     addr_t'($urandom_range(31)));
      end
      if ($urandom_range(19) == 0) drain_child_tours();
      start_crossover(addr_t'($urandom_range(31)));
    end
    drain_child_tours();
  endtask

  always @(posedge clk) begin
    child_gene_t want;
    if (!rst && results_if.valid && results_if.ready) begin
      if (expected_child_genes.size() == 0) begin
        $error("child gene at position %0d with no run pending", results_if.child_position);
        mismatch_count++;
      end else begin
        want = expected_child_genes.pop_front();
        if (results_if.child_gene !== want.child_gene) begin
          $error("child_gene: expected %0d, got %0d", want.child_gene, results_if.child_gene);
          mismatch_count++;
        end
        if (results_if.child_position !== want.child_position) begin
          $error("child_position: expected %0d, got %0d",
                 want.child_position, results_if.child_position);
          mismatch_count++;
        end
        if (results_if.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, results_if.last);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_one_point_order_crossover_core failed");
    $finish;
  end

  initial begin
    rst                = 1'b1;
    items_if.valid     = 1'b0;
    items_if.func      = FUNC_LOAD_FIRST;
    items_if.position  = '0;
    items_if.gene      = '0;
    items_if.cut_point = '0;
    requests_sent      = 0;
    mismatch_count     = 0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_random_traffic(0, 0, 45);
    test_random_traffic(87, 0, 45);
    test_random_traffic(0, 87, 45);
    test_random_traffic(36, 36, 45);

    repeat (4 * TOUR_LEN) @(posedge clk);
    if (mismatch_count == 0 && expected_child_genes.size() == 0) begin
      $display("tb_one_point_order_crossover_core passed");
    end else begin
      $display("tb_one_point_order_crossover_core failed");
    end
    $finish;
  end

endmodule
